FILE: rtl/core/fms_pkg.sv
// Shared types, mode codes and submode tables of the flight-mode supervisor.
`default_nettype none

package fms_pkg;

   // Autopilot mode numbers that the control logic tests by name
   localparam logic [4:0] MODE_KILL          = 5'd0;
   localparam logic [4:0] MODE_FAILSAFE      = 5'd1;
   localparam logic [4:0] MODE_HOME          = 5'd2;
   localparam logic [4:0] MODE_RATE_DIRECT   = 5'd3;
   localparam logic [4:0] MODE_RATE_RC_CLIMB = 5'd5;
   localparam logic [4:0] MODE_RATE_Z_HOLD   = 5'd8;
   localparam logic [4:0] MODE_NAV           = 5'd13;
   localparam logic [4:0] MODE_GUIDED        = 5'd17;
   localparam logic [4:0] NUM_MODES          = 5'd18;

   // Radio link status codes
   localparam logic [1:0] RC_OK        = 2'd0;
   localparam logic [1:0] RC_LINK_DOWN = 2'd2;

   // Command source selected by the periodic event
   localparam logic [1:0] CMD_NONE      = 2'd0;
   localparam logic [1:0] CMD_FS_FIXED  = 2'd1;
   localparam logic [1:0] CMD_FS_LOOP   = 2'd2;
   localparam logic [1:0] CMD_NORMAL    = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_MANUAL_MODE       = 3'd0;
   localparam logic [2:0] CSR_FAR_FAILSAFE_MODE = 3'd1;
   localparam logic [2:0] CSR_RC_LOST_MODE      = 3'd2;
   localparam logic [2:0] CSR_UNLOCKED_HOME     = 3'd3;
   localparam logic [2:0] CSR_RATE_AVAILABLE    = 3'd4;
   localparam logic [2:0] CSR_KILL_AS_FAILSAFE  = 3'd5;
   localparam logic [2:0] CSR_FS_ON_BATTERY     = 3'd6;
   localparam logic [2:0] CSR_GPS_CHECKS_ON     = 3'd7;

   typedef enum logic [1:0] {
      EV_RC_FRAME  = 2'd0,
      EV_PERIODIC  = 2'd1,
      EV_FS_CHECKS = 2'd2,
      EV_SETTINGS  = 2'd3
   } event_type;

   // Mode state plus the flags gathered while one event is worked through
   typedef struct packed {
      logic [4:0] mode;
      logic [1:0] horiz;
      logic [2:0] vert;
      logic [1:0] stab;
      logic [1:0] sub;
      logic       changed;
      logic       clear;
      logic       stop;
      logic       descent;
      logic       airborne;
      logic       motors;
   } sup_type;

   function automatic logic [1:0] mode_horiz(input logic [4:0] m);
      case (m)
         5'd2, 5'd13:        mode_horiz = 2'd2;
         5'd10, 5'd11, 5'd12: mode_horiz = 2'd1;
         5'd17:              mode_horiz = 2'd3;
         default:            mode_horiz = 2'd0;
      endcase
   endfunction

   function automatic logic [2:0] mode_vert(input logic [4:0] m);
      case (m)
         5'd3, 5'd4, 5'd10, 5'd14, 5'd15, 5'd16: mode_vert = 3'd1;
         5'd5, 5'd6:                             mode_vert = 3'd2;
         5'd1, 5'd7, 5'd11:                      mode_vert = 3'd3;
         5'd8, 5'd9, 5'd12:                      mode_vert = 3'd4;
         5'd2, 5'd13:                            mode_vert = 3'd5;
         5'd17:                                  mode_vert = 3'd6;
         default:                                mode_vert = 3'd0;
      endcase
   endfunction

   function automatic logic [1:0] mode_stab(input logic [4:0] m);
      case (m)
         5'd14:             mode_stab = 2'd1;
         5'd3, 5'd5, 5'd8:  mode_stab = 2'd2;
         5'd1, 5'd2, 5'd4, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
         5'd15, 5'd16, 5'd17: mode_stab = 2'd3;
         default:           mode_stab = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] mode_sub(input logic [4:0] m);
      case (m)
         5'd15:   mode_sub = 2'd2;
         5'd16:   mode_sub = 2'd1;
         default: mode_sub = 2'd0;
      endcase
   endfunction

   // Apply one mode change request to the running state
   function automatic sup_type go_mode(input sup_type s, input logic [4:0] m,
                                       input logic rate_av, input logic kaf);
      sup_type r;
      logic    rate_block;
      r = s;
      rate_block = (m inside {MODE_RATE_DIRECT, MODE_RATE_RC_CLIMB, MODE_RATE_Z_HOLD})
                   && !rate_av;
      if (m != s.mode && !(m < NUM_MODES && rate_block)) begin
         if (m < NUM_MODES) begin
            if (m == MODE_KILL || (m == MODE_FAILSAFE && kaf)) begin
               r.horiz    = 2'd0;
               r.vert     = 3'd0;
               r.stab     = 2'd0;
               r.sub      = 2'd0;
               r.clear    = 1'b1;
               r.stop     = 1'b1;
               r.airborne = 1'b0;
               r.motors   = 1'b0;
            end else begin
               r.horiz = mode_horiz(m);
               r.vert  = mode_vert(m);
               r.stab  = mode_stab(m);
               r.sub   = mode_sub(m);
               if (m == MODE_FAILSAFE) begin
                  r.descent = 1'b1;
               end
            end
         end
         r.mode    = m;
         r.changed = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/flight_mode_supervisor_core.sv
// Top level of the rotorcraft flight-mode supervisor: event stream in, mode result out.
`default_nettype none

// A request beat passes the input register, then the result register, and
// leaves as its response beat; the mode logic sits between them.
// Throughput: one beat per cycle while rsp_tready holds; the mode state is updated
// as each beat moves into the result register, so the next beat already sees it.
// Reset (synchronous, active high): mode KILL, all submodes zero, registers at
// their defaults, both stages empty.
module flight_mode_supervisor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // func
   // requested_mode[4:0], kill_switch[5], rc_status[7:6], gps_lost[8],
   // airborne[9], motors_live[10], far_from_home[11], nav_exception[12],
   // beyond_failsafe_distance[13], battery_low[14], zero[15]
   input  wire logic [15:0] req_tdata,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // mode[4:0], horizontal_mode[6:5], vertical_mode[9:7], stab_mode[11:10],
   // stab_submode[13:12], mode_changed[14], clear_airborne[15], stop_motors[16],
   // failsafe_descent[17], command_source[19:18], rc_commands[20],
   // run_home_nav[21], zero[23:22]
   output logic [23:0]      rsp_tdata,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   // Configuration registers
   logic [4:0] manual_mode_ff;
   logic [4:0] far_fs_mode_ff;
   logic [4:0] rc_lost_mode_ff;
   logic       unlocked_home_ff;
   logic       rate_avail_ff;
   logic       kill_as_fs_ff;
   logic       fs_on_bat_ff;
   logic       gps_checks_ff;

   // Mode state
   logic [4:0] mode_ff;
   logic [1:0] horiz_ff;
   logic [2:0] vert_ff;
   logic [1:0] stab_ff;
   logic [1:0] sub_ff;

   // Input stage
   logic        s1_valid_ff;
   logic [1:0]  s1_tuser_ff;
   logic [15:0] s1_tdata_ff;

   // Result stage
   logic        rsp_valid_ff;
   logic [23:0] rsp_tdata_ff;
   logic [23:0] rsp_tdata_in;

   logic        advance;

   // Fields of the beat held in the input stage
   fms_pkg::event_type ev_kind;
   logic [4:0] f_req_mode;
   logic       f_kill_sw;
   logic [1:0] f_rc_status;
   logic       f_gps_lost;
   logic       f_airborne;
   logic       f_motors_live;
   logic       f_too_far;
   logic       f_nav_exc;
   logic       f_beyond;
   logic       f_bat_crit;

   fms_pkg::sup_type sup_out;
   logic [1:0]       cmd_src;
   logic             rc_cmd;
   logic             home_nav;

   assign ev_kind       = fms_pkg::event_type'(s1_tuser_ff);
   assign f_req_mode    = s1_tdata_ff[4:0];
   assign f_kill_sw     = s1_tdata_ff[5];
   assign f_rc_status   = s1_tdata_ff[7:6];
   assign f_gps_lost    = s1_tdata_ff[8];
   assign f_airborne    = s1_tdata_ff[9];
   assign f_motors_live = s1_tdata_ff[10];
   assign f_too_far     = s1_tdata_ff[11];
   assign f_nav_exc     = s1_tdata_ff[12];
   assign f_beyond      = s1_tdata_ff[13];
   assign f_bat_crit    = s1_tdata_ff[14];

   // Move the held beat on whenever the result register is free or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Configuration port: plain register writes, unknown indexes cannot occur
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_mode_ff   <= 5'd3;
         far_fs_mode_ff   <= 5'd1;
         rc_lost_mode_ff  <= 5'd1;
         unlocked_home_ff <= 1'b0;
         rate_avail_ff    <= 1'b0;
         kill_as_fs_ff    <= 1'b0;
         fs_on_bat_ff     <= 1'b0;
         gps_checks_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            fms_pkg::CSR_MANUAL_MODE:       manual_mode_ff   <= csr_wdata;
            fms_pkg::CSR_FAR_FAILSAFE_MODE: far_fs_mode_ff   <= csr_wdata;
            fms_pkg::CSR_RC_LOST_MODE:      rc_lost_mode_ff  <= csr_wdata;
            fms_pkg::CSR_UNLOCKED_HOME:     unlocked_home_ff <= csr_wdata[0];
            fms_pkg::CSR_RATE_AVAILABLE:    rate_avail_ff    <= csr_wdata[0];
            fms_pkg::CSR_KILL_AS_FAILSAFE:  kill_as_fs_ff    <= csr_wdata[0];
            fms_pkg::CSR_FS_ON_BATTERY:     fs_on_bat_ff     <= csr_wdata[0];
            fms_pkg::CSR_GPS_CHECKS_ON:     gps_checks_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Event logic: work the held beat against the current mode state.
   // Several mode changes in one event chain through go_mode in order,
   // so a kill entered early clears the in-flight and motor flags seen later.
   always_comb begin
      fms_pkg::sup_type st;
      st.mode      = mode_ff;
      st.horiz     = horiz_ff;
      st.vert      = vert_ff;
      st.stab      = stab_ff;
      st.sub       = sub_ff;
      st.changed   = 1'b0;
      st.clear     = 1'b0;
      st.stop      = 1'b0;
      st.descent   = 1'b0;
      st.airborne  = f_airborne;
      st.motors    = f_motors_live;
      cmd_src      = fms_pkg::CMD_NONE;
      rc_cmd       = 1'b0;
      home_nav     = 1'b0;

      case (ev_kind)
         fms_pkg::EV_RC_FRAME: begin
            if (f_kill_sw) begin
               st = fms_pkg::go_mode(st, fms_pkg::MODE_KILL, rate_avail_ff, kill_as_fs_ff);
            end else if (!(f_req_mode == fms_pkg::MODE_NAV && f_gps_lost)) begin
               // HOME and FAILSAFE are locked unless the manual mode is asked for or home is unlocked and not too far
               if (f_req_mode == manual_mode_ff ||
                   (st.mode != fms_pkg::MODE_HOME && st.mode != fms_pkg::MODE_FAILSAFE) ||
                   (unlocked_home_ff && !f_too_far)) begin
                  st = fms_pkg::go_mode(st, f_req_mode, rate_avail_ff, kill_as_fs_ff);
               end
            end
            rc_cmd = st.mode != fms_pkg::MODE_FAILSAFE && st.mode != fms_pkg::MODE_HOME &&
                     st.mode != fms_pkg::MODE_NAV;
         end
         fms_pkg::EV_PERIODIC: begin
            // Escalate navigation trouble: home, or the far failsafe mode
            if (st.airborne && st.mode == fms_pkg::MODE_NAV && (f_too_far || f_nav_exc)) begin
               st = fms_pkg::go_mode(st, f_beyond ? far_fs_mode_ff : fms_pkg::MODE_HOME,
                                     rate_avail_ff, kill_as_fs_ff);
            end
            home_nav = st.mode == fms_pkg::MODE_HOME;
            // Failsafe on the ground drops to kill
            if (st.mode == fms_pkg::MODE_FAILSAFE && !st.airborne) begin
               st = fms_pkg::go_mode(st, fms_pkg::MODE_KILL, rate_avail_ff, kill_as_fs_ff);
            end
            if (st.mode == fms_pkg::MODE_FAILSAFE && !kill_as_fs_ff) begin
               cmd_src = fms_pkg::CMD_FS_LOOP;
            end else if (st.mode == fms_pkg::MODE_FAILSAFE || st.mode == fms_pkg::MODE_KILL) begin
               cmd_src = fms_pkg::CMD_FS_FIXED;
            end else begin
               cmd_src = fms_pkg::CMD_NORMAL;
            end
         end
         fms_pkg::EV_FS_CHECKS: begin
            // Radio really lost while in a manual mode
            if (f_rc_status == fms_pkg::RC_LINK_DOWN && st.mode != fms_pkg::MODE_KILL &&
                st.mode != fms_pkg::MODE_HOME && st.mode != fms_pkg::MODE_FAILSAFE &&
                st.mode != fms_pkg::MODE_NAV && st.mode != fms_pkg::MODE_GUIDED) begin
               st = fms_pkg::go_mode(st, rc_lost_mode_ff, rate_avail_ff, kill_as_fs_ff);
            end
            if (fs_on_bat_ff && st.mode != fms_pkg::MODE_KILL && f_bat_crit) begin
               st = fms_pkg::go_mode(st, fms_pkg::MODE_FAILSAFE, rate_avail_ff, kill_as_fs_ff);
            end
            if (gps_checks_ff) begin
               if (st.mode == fms_pkg::MODE_NAV && st.motors && f_gps_lost) begin
                  st = fms_pkg::go_mode(st, fms_pkg::MODE_FAILSAFE, rate_avail_ff,
                                        kill_as_fs_ff);
               end
               if (st.mode == fms_pkg::MODE_HOME && st.motors && f_gps_lost) begin
                  st = fms_pkg::go_mode(st, fms_pkg::MODE_FAILSAFE, rate_avail_ff,
                                        kill_as_fs_ff);
               end
            end
         end
         fms_pkg::EV_SETTINGS: begin
            // Navigation modes from settings only while the radio is not OK
            if (f_req_mode == fms_pkg::MODE_KILL || f_req_mode == fms_pkg::MODE_FAILSAFE ||
                f_req_mode == fms_pkg::MODE_HOME) begin
               st = fms_pkg::go_mode(st, f_req_mode, rate_avail_ff, kill_as_fs_ff);
            end else if (f_rc_status != fms_pkg::RC_OK &&
                         (f_req_mode == fms_pkg::MODE_NAV ||
                          f_req_mode == fms_pkg::MODE_GUIDED)) begin
               st = fms_pkg::go_mode(st, f_req_mode, rate_avail_ff, kill_as_fs_ff);
            end
         end
         default: ;
      endcase
      sup_out = st;
   end

   assign rsp_tdata_in = {2'b00, home_nav, rc_cmd, cmd_src, sup_out.descent, sup_out.stop,
                          sup_out.clear, sup_out.changed, sup_out.sub, sup_out.stab,
                          sup_out.vert, sup_out.horiz, sup_out.mode};

   // Input stage: take a beat whenever the stage is empty or moving on
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_tuser_ff <= req_tuser;
         s1_tdata_ff <= req_tdata;
      end
   end

   // Mode state: commit as the beat moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= fms_pkg::MODE_KILL;
         horiz_ff <= 2'd0;
         vert_ff  <= 3'd0;
         stab_ff  <= 2'd0;
         sub_ff   <= 2'd0;
      end else if (advance) begin
         mode_ff  <= sup_out.mode;
         horiz_ff <= sup_out.horiz;
         vert_ff  <= sup_out.vert;
         stab_ff  <= sup_out.stab;
         sub_ff   <= sup_out.sub;
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // A kill-type entry always raises both kill flags and counts as a change
   a_kill_flags : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tdata_ff[15]) |-> (rsp_tdata_ff[16] && rsp_tdata_ff[14]))
      else $error("clear flag without stop_motors or mode_changed");

   // KILL always comes with all submodes cleared
   a_kill_submodes : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tdata_ff[4:0] == fms_pkg::MODE_KILL) |->
      (rsp_tdata_ff[13:5] == 9'd0))
      else $error("KILL reported with non-zero submodes");

   // The mode register moves only when a beat advances
   a_mode_hold : assert property (@(posedge clock) disable iff (reset)
      (!advance) |=> $stable(mode_ff))
      else $error("mode state changed without an advancing beat");

endmodule

`default_nettype wire
